>>> design/ice_pkg.sv
// Shared types and constants for the interface crossing event tracker.
`timescale 1ns / 1ps

package ice_pkg;

  localparam logic [31:0] CODE_ENTER = 32'h4040_0000;
  localparam logic [31:0] CODE_AWAY  = 32'h3F80_0000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [1:0] {
    PH_NEVER  = 2'd0,
    PH_INSIDE = 2'd1,
    PH_LEFT   = 2'd2,
    PH_ENDED  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [31:0] frame_index;
    logic [15:0] particle_id;
    logic        is_enter;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
  } item_t;

  typedef struct packed {
    logic [31:0] frame;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
  } start_t;

endpackage

>>> design/ice_fifo.sv
// Short queue between the front and back parts of the tracker.
`timescale 1ns / 1ps

module ice_fifo #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);

  logic [DATA_W-1:0]         mem_r [ice_pkg::QUEUE_DEPTH];
  logic [ice_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [ice_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [ice_pkg::QPTR_W:0]   count_r;
  logic                       do_push;
  logic                       do_pop;

  assign full     = (count_r == (ice_pkg::QPTR_W + 1)'(ice_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> design/ice_front.sv
// Front part: accepts observations, classifies the code and reduces the id to a table slot.
`timescale 1ns / 1ps

module ice_front #(
  parameter int ID_COUNT = 65536
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [31:0]                 in_frame_index,
  input  logic [15:0]                 in_particle_id,
  input  logic [31:0]                 in_region_code,
  input  logic [31:0]                 in_pos_x,
  input  logic [31:0]                 in_pos_y,
  input  logic [31:0]                 in_pos_z,
  input  logic                        clearing,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [$clog2(ID_COUNT)-1:0] q_slot,
  output ice_pkg::item_t              q_item
);

  localparam int          SLOT_W = $clog2(ID_COUNT);
  localparam int          RW     = (SLOT_W > 16) ? SLOT_W : 16;
  localparam logic [63:0] IDC    = 64'(ID_COUNT);

  logic           a_valid_r;
  logic           a_valid_nxt;
  ice_pkg::item_t a_item_r;
  logic [RW-1:0]  a_rem_r;
  logic [RW-1:0]  rem_a;
  logic [RW-1:0]  rem_b;
  logic           is_enter;
  logic           is_away;
  logic           in_take;

  assign is_enter = (in_region_code == ice_pkg::CODE_ENTER);
  assign is_away  = (in_region_code == ice_pkg::CODE_AWAY);
  assign in_stall = clearing || (a_valid_r && q_full);
  assign in_take  = in_valid && !in_stall && (is_enter || is_away);
  assign q_push   = a_valid_r && !q_full;

  // The id is reduced modulo the table size by conditional subtraction, upper half here.
  always_comb begin
    rem_a = RW'(in_particle_id);
    for (int k = 15; k >= 8; k--) begin
      if ((IDC << k) <= 64'hFFFF) begin
        if (rem_a >= RW'(IDC << k)) begin
          rem_a = rem_a - RW'(IDC << k);
        end
      end
    end
  end

  always_comb begin
    rem_b = a_rem_r;
    for (int k = 7; k >= 0; k--) begin
      if ((IDC << k) <= 64'hFFFF) begin
        if (rem_b >= RW'(IDC << k)) begin
          rem_b = rem_b - RW'(IDC << k);
        end
      end
    end
  end

  assign q_slot = rem_b[SLOT_W-1:0];
  assign q_item = a_item_r;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_take) begin
      a_valid_nxt = 1'b1;
    end else if (q_push) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_rem_r              <= rem_a;
      a_item_r.frame_index <= in_frame_index;
      a_item_r.particle_id <= in_particle_id;
      a_item_r.is_enter    <= is_enter;
      a_item_r.pos_x       <= in_pos_x;
      a_item_r.pos_y       <= in_pos_y;
      a_item_r.pos_z       <= in_pos_z;
    end
  end

endmodule

>>> design/ice_back.sv
// Back part: phase table read-modify-write, start tables and the result register.
`timescale 1ns / 1ps

module ice_back #(
  parameter int ID_COUNT = 65536
) (
  input  logic                        clk,
  input  logic                        rst_n,
  output logic                        clearing,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  logic [$clog2(ID_COUNT)-1:0] q_slot,
  input  ice_pkg::item_t              q_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [15:0]                 out_event_id,
  output logic [31:0]                 out_start_frame,
  output logic [31:0]                 out_end_frame,
  output logic [31:0]                 out_start_x,
  output logic [31:0]                 out_start_y,
  output logic [31:0]                 out_start_z,
  output logic [31:0]                 out_end_x,
  output logic [31:0]                 out_end_y,
  output logic [31:0]                 out_end_z
);

  localparam int              SLOT_W    = $clog2(ID_COUNT);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ID_COUNT - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  logic [SLOT_W-1:0]   clr_r;
  logic [SLOT_W-1:0]   clr_nxt;
  ice_pkg::item_t      item_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                out_valid_r;
  logic                out_valid_nxt;

  ice_pkg::phase_t     phase_mem [ID_COUNT];
  ice_pkg::start_t     start_mem [ID_COUNT];
  ice_pkg::phase_t     phase_rd_r;
  ice_pkg::start_t     start_rd_r;

  logic                phase_we;
  logic [SLOT_W-1:0]   phase_wa;
  ice_pkg::phase_t     phase_wd;
  logic                start_we;
  logic                want_emit;
  logic                hold_exec;
  logic                emit;
  logic                out_free;

  assign clearing  = (state_r == S_CLEAR);
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    phase_we  = 1'b0;
    phase_wa  = slot_r;
    phase_wd  = ice_pkg::PH_NEVER;
    start_we  = 1'b0;
    want_emit = 1'b0;
    hold_exec = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        phase_we = 1'b1;
        phase_wa = clr_r;
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (q_pop) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (item_r.is_enter) begin
          if (phase_rd_r != ice_pkg::PH_INSIDE) begin
            phase_we = 1'b1;
            phase_wd = ice_pkg::PH_INSIDE;
            start_we = 1'b1;
          end
        end else if (phase_rd_r == ice_pkg::PH_INSIDE) begin
          phase_we = 1'b1;
          phase_wd = ice_pkg::PH_LEFT;
        end else if (phase_rd_r == ice_pkg::PH_LEFT) begin
          phase_we  = 1'b1;
          phase_wd  = ice_pkg::PH_ENDED;
          want_emit = 1'b1;
        end
        hold_exec = want_emit && !out_free;
        if (hold_exec) begin
          phase_we = 1'b0;
        end else begin
          emit      = want_emit;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        item_r <= q_item;
        slot_r <= q_slot;
      end
      if (emit) begin
        out_event_id    <= item_r.particle_id;
        out_start_frame <= start_rd_r.frame;
        out_end_frame   <= item_r.frame_index;
        out_start_x     <= start_rd_r.pos_x;
        out_start_y     <= start_rd_r.pos_y;
        out_start_z     <= start_rd_r.pos_z;
        out_end_x       <= item_r.pos_x;
        out_end_y       <= item_r.pos_y;
        out_end_z       <= item_r.pos_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (phase_we) begin
      phase_mem[phase_wa] <= phase_wd;
    end
    if (q_pop) begin
      phase_rd_r <= phase_mem[q_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (start_we) begin
      start_mem[slot_r] <= '{frame: item_r.frame_index, pos_x: item_r.pos_x,
                             pos_y: item_r.pos_y, pos_z: item_r.pos_z};
    end
    if (q_pop) begin
      start_rd_r <= start_mem[q_slot];
    end
  end

endmodule

>>> design/interface_crossing_event_tracker.sv
// Top level of the interface crossing event tracker.
//
//   Channel   Ports                               Direction  Beat
//   in        in_valid, in_stall, in_* fields      input      one observation
//   out       out_valid, out_stall, out_* fields   output     one residence record
//
// An observation with a code other than enter or away is dropped at the front.
// The back handles each enter or away observation as a table read in S_IDLE, then the write in S_EXEC.
// After reset the phase table is cleared one entry per cycle, all ID_COUNT entries, with in_stall high.
// A held result stalls the back only when the next observation also ends a residence.
`timescale 1ns / 1ps

module interface_crossing_event_tracker #(
  parameter int ID_COUNT = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_frame_index,
  input  logic [15:0] in_particle_id,
  input  logic [31:0] in_region_code,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_event_id,
  output logic [31:0] out_start_frame,
  output logic [31:0] out_end_frame,
  output logic [31:0] out_start_x,
  output logic [31:0] out_start_y,
  output logic [31:0] out_start_z,
  output logic [31:0] out_end_x,
  output logic [31:0] out_end_y,
  output logic [31:0] out_end_z
);

  localparam int SLOT_W = $clog2(ID_COUNT);
  localparam int QW     = $bits(ice_pkg::item_t) + SLOT_W;

  logic              clearing;
  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  logic [SLOT_W-1:0] push_slot;
  ice_pkg::item_t    push_item;
  logic [QW-1:0]     pop_data;
  logic [SLOT_W-1:0] pop_slot;
  ice_pkg::item_t    pop_item;

  ice_front #(
    .ID_COUNT(ID_COUNT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_frame_index(in_frame_index),
    .in_particle_id(in_particle_id),
    .in_region_code(in_region_code),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .clearing      (clearing),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_slot        (push_slot),
    .q_item        (push_item)
  );

  ice_fifo #(
    .DATA_W(QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data({push_slot, push_item}),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (pop_data),
    .empty    (q_empty)
  );

  assign pop_slot = pop_data[QW-1 -: SLOT_W];
  assign pop_item = ice_pkg::item_t'(pop_data[$bits(ice_pkg::item_t)-1:0]);

  ice_back #(
    .ID_COUNT(ID_COUNT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .clearing       (clearing),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_slot         (pop_slot),
    .q_item         (pop_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_id   (out_event_id),
    .out_start_frame(out_start_frame),
    .out_end_frame  (out_end_frame),
    .out_start_x    (out_start_x),
    .out_start_y    (out_start_y),
    .out_start_z    (out_start_z),
    .out_end_x      (out_end_x),
    .out_end_y      (out_end_y),
    .out_end_z      (out_end_z)
  );

endmodule
